[design/pmlod_pkg.sv]
// Shared types and constants of the progressive-mesh level-of-detail engine.
package pmlod_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int TARGET_W    = 18;

  // Target used when no distance points are loaded: above any reachable count.
  localparam logic [TARGET_W-1:0] FULL_DETAIL_TARGET = {TARGET_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] CFG_COLLAPSE_COUNT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOD_POINT_COUNT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VERTICES    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INDICES     = 4'd3;

  typedef enum logic [2:0] {
    REQ_LOAD_INDEX  = 3'd0,
    REQ_LOAD_CHANGE = 3'd1,
    REQ_LOAD_RECORD = 3'd2,
    REQ_LOAD_LOD    = 3'd3,
    REQ_RESTART     = 3'd4,
    REQ_SET_VERTS   = 3'd5,
    REQ_SET_DIST    = 3'd6,
    REQ_READ_INDEX  = 3'd7
  } req_t;

  typedef struct packed {
    req_t        kind;
    logic [12:0] address;
    logic [15:0] word_value;
    logic [15:0] vertices_to_lose;
    logic [15:0] indices_to_lose;
    logic [12:0] change_start;
    logic [13:0] change_count;
    logic        should_collapse;
    logic [31:0] distance;
    logic [15:0] target_vertices;
  } cmd_t;

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] vlose;
    logic [15:0] ilose;
    logic [12:0] cstart;
    logic [13:0] ccount;
    logic        should;
  } rec_t;

  typedef struct packed {
    logic [10:0] collapse_count;
    logic [3:0]  lod_point_count;
    logic [15:0] min_vertices;
    logic [15:0] min_indices;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_SHOULD = 2'd2
  } mode_t;

endpackage

[design/progressive_mesh_lod_engine.sv]
// Top level of the progressive-mesh level-of-detail engine.
//
// The engine holds an index store, a change list, a table of collapse records and a
// table of up to LOD_POINTS distance points, together with the level pointer and the
// current vertex and index counts. Every request returns exactly one result carrying
// the read word (zero unless the request was an index read), both counts and the
// current detail level. Load, restart and read requests are carried out as they
// leave the queue and go straight to the result. A set-by-vertices request reads
// each record it visits and then each change entry of every record split or
// collapsed, since the record table and the change list each have a single read
// port and entries are fetched one per cycle. A set-by-distance request may first
// search the point table and pass through a multiplier and a bit-serial divider
// before the same walk. Requests are queued two deep in front of the executing back
// end, and a finished result waits in an output register, so the input side keeps
// taking requests while a result is not yet taken. Configuration writes are always
// accepted and should be made only while the engine is idle. Tables come out of
// reset undefined; only the pointer and the counts are cleared.
module progressive_mesh_lod_engine import pmlod_pkg::*; #(
  parameter int MAX_INDICES = 4096,
  parameter int MAX_CHANGES = 8192,
  parameter int MAX_RECORDS = 1024,
  parameter int LOD_POINTS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata from bit 0: address[13], word_value[16], vertices_to_lose[16],
  // indices_to_lose[16], change_start[13], change_count[14], should_collapse[1],
  // distance[32], target_vertices[16], zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: req_type[3].
  input  logic [2:0]             in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata from bit 0: read_word[16], vertex_count[16], index_count[16],
  // detail_level[11], zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Registers are written directly, so the channel never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLLAPSE_COUNT:  cfg_nxt.collapse_count  = cfg_data[10:0];
        CFG_LOD_POINT_COUNT: cfg_nxt.lod_point_count = cfg_data[3:0];
        CFG_MIN_VERTICES:    cfg_nxt.min_vertices    = cfg_data;
        CFG_MIN_INDICES:     cfg_nxt.min_indices     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: unpacks each request and holds it until the back end is free.
  pmlod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Back end: owns the tables and runs loads, reads and the detail walk.
  pmlod_back #(
    .MAX_INDICES (MAX_INDICES),
    .MAX_CHANGES (MAX_CHANGES),
    .MAX_RECORDS (MAX_RECORDS),
    .LOD_POINTS  (LOD_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[design/pmlod_front.sv]
// Request front end: unpacks and classifies requests into a two-entry queue.
module pmlod_front import pmlod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_pop
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.kind             = req_t'(in_tuser);
    cmd_in.address          = in_tdata[12:0];
    cmd_in.word_value       = in_tdata[28:13];
    cmd_in.vertices_to_lose = in_tdata[44:29];
    cmd_in.indices_to_lose  = in_tdata[60:45];
    cmd_in.change_start     = in_tdata[73:61];
    cmd_in.change_count     = in_tdata[87:74];
    cmd_in.should_collapse  = in_tdata[88];
    cmd_in.distance         = in_tdata[120:89];
    cmd_in.target_vertices  = in_tdata[136:121];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule

[design/pmlod_back.sv]
// Execution back end: tables, level walk, distance lookup and result register.
module pmlod_back import pmlod_pkg::*; #(
  parameter int MAX_INDICES = 4096,
  parameter int MAX_CHANGES = 8192,
  parameter int MAX_RECORDS = 1024,
  parameter int LOD_POINTS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IAW = $clog2(MAX_INDICES);
  localparam int CAW = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
  localparam int RAW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int LAW = (LOD_POINTS > 1) ? $clog2(LOD_POINTS) : 1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_START   = 10'b0000000010,
    S_WALK    = 10'b0000000100,
    S_STEP    = 10'b0000001000,
    S_APPLY   = 10'b0000010000,
    S_DSEARCH = 10'b0000100000,
    S_DMUL    = 10'b0001000000,
    S_DDIV    = 10'b0010000000,
    S_RESP    = 10'b0100000000,
    S_SPARE   = 10'b1000000000
  } state_t;

  // Storage.
  logic [15:0]  idx_mem [MAX_INDICES];
  logic [IAW:0] chg_mem [MAX_CHANGES];
  rec_t         rec_mem [MAX_RECORDS];
  logic [31:0]  lod_dist_r [LOD_POINTS];
  logic [15:0]  lod_vert_r [LOD_POINTS];

  logic [15:0]  idx_q_r;
  logic [IAW:0] chg_q_r;
  rec_t         rec_q_r;

  // Memory port controls.
  logic           idx_we, idx_re, chg_we, chg_re, rec_we, rec_re, lod_we;
  logic [IAW-1:0] idx_wa, idx_ra;
  logic [15:0]    idx_wd;
  logic [CAW-1:0] chg_wa, chg_ra;
  logic [IAW:0]   chg_wd;
  logic [RAW-1:0] rec_wa, rec_ra;
  logic [LAW-1:0] lod_wa, lix;

  // Control and working registers.
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [10:0]   ptr_r, ptr_nxt;
  logic [15:0]   cv_r, cv_nxt;
  logic [15:0]   ci_r, ci_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [15:0]   word_r, word_nxt;
  logic [13:0]   j_r, j_nxt;
  logic          pend_r, pend_nxt;
  logic          rd_hit_r, rd_hit_nxt;
  logic [31:0]   d_r, d_nxt;
  logic [3:0]    i_r, i_nxt;
  logic [31:0]   pd_r, pd_nxt;
  logic [15:0]   pv_r, pv_nxt;
  logic          neg_r, neg_nxt;
  logic [15:0]   mag_r, mag_nxt;
  logic [31:0]   dd_r, dd_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [47:0]   rem_r, rem_nxt;
  logic [15:0]   quo_r, quo_nxt;
  logic [3:0]    k_r, k_nxt;

  logic [10:0]   active;
  logic [3:0]    npts;
  logic [14:0]   slot;
  logic [47:0]   dsh;
  logic [15:0]   quo_new;
  logic [15:0]   out_word;

  assign active = (32'(cfg.collapse_count) < MAX_RECORDS) ? cfg.collapse_count
                                                          : 11'(MAX_RECORDS);
  assign npts   = (32'(cfg.lod_point_count) < LOD_POINTS) ? cfg.lod_point_count
                                                           : 4'(LOD_POINTS);
  assign lix    = (state_r == S_IDLE) ? LAW'(npts - 4'd1) : LAW'(i_r);
  assign slot   = 15'(rec_q_r.cstart) + 15'(j_r);
  assign dsh    = {16'b0, den_r} << k_r;
  assign out_word = rd_hit_r ? idx_q_r : 16'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ptr_nxt       = ptr_r;
    cv_nxt        = cv_r;
    ci_nxt        = ci_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    target_nxt    = target_r;
    word_nxt      = word_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    rd_hit_nxt    = rd_hit_r;
    d_nxt         = d_r;
    i_nxt         = i_r;
    pd_nxt        = pd_r;
    pv_nxt        = pv_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dd_nxt        = dd_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    k_nxt         = k_r;
    quo_new       = quo_r;
    q_pop         = 1'b0;
    idx_we = 1'b0; idx_re = 1'b0; chg_we = 1'b0; chg_re = 1'b0;
    rec_we = 1'b0; rec_re = 1'b0; lod_we = 1'b0;
    idx_wa = IAW'(q_cmd.address);
    idx_ra = IAW'(q_cmd.address);
    idx_wd = q_cmd.word_value;
    chg_wa = CAW'(q_cmd.address);
    chg_ra = CAW'(slot);
    chg_wd = {(32'(q_cmd.word_value) < MAX_INDICES), IAW'(q_cmd.word_value)};
    rec_wa = RAW'(q_cmd.address);
    rec_ra = RAW'(ptr_r);
    lod_wa = LAW'(q_cmd.address);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_hit_nxt = 1'b0;
          state_nxt  = S_RESP;
          unique case (q_cmd.kind)
            REQ_LOAD_INDEX: idx_we = (32'(q_cmd.address) < MAX_INDICES);
            REQ_LOAD_CHANGE: chg_we = (32'(q_cmd.address) < MAX_CHANGES);
            REQ_LOAD_RECORD: rec_we = (32'(q_cmd.address) < MAX_RECORDS);
            REQ_LOAD_LOD: lod_we = (32'(q_cmd.address) < LOD_POINTS);
            REQ_RESTART: begin
              ptr_nxt = 11'd0;
              cv_nxt  = cfg.min_vertices;
              ci_nxt  = cfg.min_indices;
            end
            REQ_SET_VERTS: begin
              target_nxt = TARGET_W'(q_cmd.target_vertices);
              state_nxt  = S_START;
            end
            REQ_SET_DIST: begin
              d_nxt = q_cmd.distance;
              priority if (npts == 4'd0) begin
                target_nxt = FULL_DETAIL_TARGET;
                state_nxt  = S_START;
              end else if (q_cmd.distance < lod_dist_r[0]) begin
                target_nxt = TARGET_W'(lod_vert_r[0]);
                state_nxt  = S_START;
              end else if (lod_dist_r[lix] < q_cmd.distance) begin
                target_nxt = TARGET_W'(lod_vert_r[lix]);
                state_nxt  = S_START;
              end else begin
                i_nxt     = 4'd1;
                pd_nxt    = lod_dist_r[0];
                pv_nxt    = lod_vert_r[0];
                state_nxt = S_DSEARCH;
              end
            end
            REQ_READ_INDEX: begin
              idx_re     = 1'b1;
              rd_hit_nxt = (32'(q_cmd.address) < MAX_INDICES);
            end
            default: ;
          endcase
        end
      end

      S_START: begin
        if (target_r == TARGET_W'(cv_r)) begin
          state_nxt = S_RESP;
        end else begin
          mode_nxt  = (target_r > TARGET_W'(cv_r)) ? MODE_UP : MODE_DOWN;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        unique case (mode_r)
          MODE_UP: begin
            if ((target_r > TARGET_W'(cv_r)) && (ptr_r < active)) begin
              rec_re    = 1'b1;
              state_nxt = S_STEP;
            end else begin
              mode_nxt = MODE_SHOULD;
            end
          end
          MODE_DOWN: begin
            if ((target_r < TARGET_W'(cv_r)) && (ptr_r != 11'd0)) begin
              rec_re    = 1'b1;
              rec_ra    = RAW'(ptr_r - 11'd1);
              ptr_nxt   = ptr_r - 11'd1;
              state_nxt = S_STEP;
            end else begin
              mode_nxt = MODE_SHOULD;
            end
          end
          default: begin
            if (ptr_r < active) begin
              rec_re    = 1'b1;
              state_nxt = S_STEP;
            end else begin
              state_nxt = S_RESP;
            end
          end
        endcase
      end

      S_STEP: begin
        j_nxt    = 14'd0;
        pend_nxt = 1'b0;
        if (mode_r == MODE_DOWN) begin
          ci_nxt    = ci_r - rec_q_r.ilose;
          cv_nxt    = cv_r - rec_q_r.vlose;
          word_nxt  = rec_q_r.target;
          state_nxt = S_APPLY;
        end else if ((mode_r == MODE_UP) &&
                     (TARGET_W'(cv_r) + TARGET_W'(rec_q_r.vlose) > target_r)) begin
          mode_nxt  = MODE_SHOULD;
          state_nxt = S_WALK;
        end else if ((mode_r == MODE_SHOULD) && !rec_q_r.should) begin
          state_nxt = S_RESP;
        end else begin
          ci_nxt    = ci_r + rec_q_r.ilose;
          cv_nxt    = cv_r + rec_q_r.vlose;
          word_nxt  = cv_r + rec_q_r.vlose - 16'd1;
          ptr_nxt   = ptr_r + 11'd1;
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        // One change entry is fetched per cycle; its index word is written in the next cycle.
        if (j_r < rec_q_r.ccount) begin
          chg_re   = (32'(slot) < MAX_CHANGES);
          pend_nxt = (32'(slot) < MAX_CHANGES);
          j_nxt    = j_r + 14'd1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_WALK;
          end
        end
        if (pend_r && chg_q_r[IAW]) begin
          idx_we = 1'b1;
          idx_wa = chg_q_r[IAW-1:0];
          idx_wd = word_r;
        end
      end

      S_DSEARCH: begin
        if (i_r < npts) begin
          if (d_r < lod_dist_r[lix]) begin
            neg_nxt   = (lod_vert_r[lix] < pv_r);
            mag_nxt   = (lod_vert_r[lix] < pv_r) ? (pv_r - lod_vert_r[lix])
                                                 : (lod_vert_r[lix] - pv_r);
            dd_nxt    = d_r - pd_r;
            den_nxt   = lod_dist_r[lix] - pd_r;
            state_nxt = S_DMUL;
          end else begin
            pd_nxt = lod_dist_r[lix];
            pv_nxt = lod_vert_r[lix];
            i_nxt  = i_r + 4'd1;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_DMUL: begin
        rem_nxt   = {32'b0, mag_r} * {16'b0, dd_r};
        quo_nxt   = 16'd0;
        k_nxt     = 4'd15;
        state_nxt = S_DDIV;
      end

      S_DDIV: begin
        // Restoring division, one quotient bit per cycle from the top.
        if (rem_r >= dsh) begin
          rem_nxt       = rem_r - dsh;
          quo_new[k_r]  = 1'b1;
        end
        quo_nxt = quo_new;
        k_nxt   = k_r - 4'd1;
        if (k_r == 4'd0) begin
          target_nxt = neg_r ? TARGET_W'(pv_r - quo_new) : TARGET_W'(pv_r + quo_new);
          state_nxt  = S_START;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, ptr_r, ci_r, cv_r, out_word};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= 11'd0;
      cv_r        <= 16'd0;
      ci_r        <= 16'd0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cv_r        <= cv_nxt;
      ci_r        <= ci_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    out_data_r <= out_data_nxt;
    target_r   <= target_nxt;
    word_r     <= word_nxt;
    j_r        <= j_nxt;
    rd_hit_r   <= rd_hit_nxt;
    d_r        <= d_nxt;
    i_r        <= i_nxt;
    pd_r       <= pd_nxt;
    pv_r       <= pv_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    dd_r       <= dd_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    k_r        <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_wa] <= idx_wd;
    if (idx_re) idx_q_r <= idx_mem[idx_ra];
  end

  always_ff @(posedge clk) begin
    if (chg_we) chg_mem[chg_wa] <= chg_wd;
    if (chg_re) chg_q_r <= chg_mem[chg_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= '{target: q_cmd.word_value, vlose: q_cmd.vertices_to_lose,
                           ilose: q_cmd.indices_to_lose, cstart: q_cmd.change_start,
                           ccount: q_cmd.change_count, should: q_cmd.should_collapse};
    end
    if (rec_re) rec_q_r <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (lod_we) begin
      lod_dist_r[lod_wa] <= q_cmd.distance;
      lod_vert_r[lod_wa] <= q_cmd.word_value;
    end
  end

endmodule

[dv/progressive_mesh_lod_engine_tb.sv]
// Self-checking testbench of the progressive-mesh level-of-detail engine.
module progressive_mesh_lod_engine_tb;
  import pmlod_pkg::*;

  localparam int IDX_DEPTH = 4096;
  localparam int CHG_DEPTH = 8192;
  localparam int REC_DEPTH = 1024;
  localparam int LOD_DEPTH = 8;
  localparam int SEED_RECORDS = 64;   // records loaded before any walk is asked for
  localparam int CHG_WINDOW = 256;    // change entries loaded before any walk
  localparam int RAND_PER_PHASE = 330;
  localparam longint CYCLE_LIMIT = 200000000;

  // One result of the engine, highest field first so that it lines up with out_tdata.
  typedef struct packed {
    logic [10:0] level;
    logic [15:0] indices;
    logic [15:0] verts;
    logic [15:0] word;
  } lod_result_t;

  typedef struct {
    cmd_t        cmd;
    bit          typed;
    lod_result_t fixed;
  } lod_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  progressive_mesh_lod_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the engine's tables, pointer, counts and registers.
  logic [15:0] idx_mem [IDX_DEPTH];
  logic [15:0] chg_mem [CHG_DEPTH];
  rec_t        rec_mem [REC_DEPTH];
  logic [31:0] lod_dist [LOD_DEPTH];
  logic [15:0] lod_vert [LOD_DEPTH];
  int unsigned level_ptr;
  int unsigned cur_verts;
  int unsigned cur_indices;
  cfg_t        regs;

  // Which entries have been written, so that the stimulus never reads an undefined one.
  bit rec_loaded [REC_DEPTH];
  int idx_written [$];

  lod_result_t expected_results [$];
  int          errors;
  int          tx_idle;
  int          rx_idle;
  int          phase;
  bit          rx_hold;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall watchdog: the slowest legal run sits far below this.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------

  function automatic int unsigned records_in_use();
    return (regs.collapse_count < REC_DEPTH) ? regs.collapse_count : REC_DEPTH;
  endfunction

  // Rewrites every index word named by one record's change entries.
  function automatic void rewrite_indices(int unsigned r, logic [15:0] w);
    int unsigned slot;
    for (int unsigned j = 0; j < rec_mem[r].ccount; j++) begin
      slot = rec_mem[r].cstart + j;
      if (slot >= CHG_DEPTH) break;
      if (chg_mem[slot] < IDX_DEPTH) idx_mem[chg_mem[slot]] = w;
    end
  endfunction

  // Walks the records toward a vertex target. In a trial run nothing is committed and
  // the return value says whether the walk stays on records that have been loaded.
  function automatic bit walk_to_target(longint goal, bit trial);
    int unsigned lv;
    int unsigned v;
    int unsigned ix;
    int unsigned act;
    lv  = level_ptr;
    v   = cur_verts;
    ix  = cur_indices;
    act = records_in_use();
    if (goal == longint'(v)) return 1'b1;
    if (goal > longint'(v)) begin
      while (goal > longint'(v)) begin
        if (lv >= act) break;
        if (!rec_loaded[lv]) return 1'b0;
        // Overshoot test in full precision.
        if (longint'(rec_mem[lv].vlose) + longint'(v) > goal) break;
        ix = (ix + rec_mem[lv].ilose) & 16'hFFFF;
        v  = (v + rec_mem[lv].vlose) & 16'hFFFF;
        if (!trial) rewrite_indices(lv, 16'(v - 1));
        lv++;
      end
    end else begin
      while (goal < longint'(v)) begin
        if (lv == 0) break;
        lv--;
        if (!rec_loaded[lv]) return 1'b0;
        ix = (ix - rec_mem[lv].ilose) & 16'hFFFF;
        if (!trial) rewrite_indices(lv, rec_mem[lv].target);
        v = (v - rec_mem[lv].vlose) & 16'hFFFF;
      end
    end
    // Keep splitting while the next record asks for it; past the end it reads false.
    while (lv < act) begin
      if (!rec_loaded[lv]) return 1'b0;
      if (!rec_mem[lv].should) break;
      ix = (ix + rec_mem[lv].ilose) & 16'hFFFF;
      v  = (v + rec_mem[lv].vlose) & 16'hFFFF;
      if (!trial) rewrite_indices(lv, 16'(v - 1));
      lv++;
    end
    if (!trial) begin
      level_ptr   = lv;
      cur_verts   = v;
      cur_indices = ix;
    end
    return 1'b1;
  endfunction

  // Piecewise-linear lookup of a vertex target; returns 0 where no segment matches.
  function automatic bit target_from_distance(logic [31:0] d, output longint goal);
    int unsigned n;
    int unsigned last;
    longint      num;
    longint      den;
    n = (regs.lod_point_count < LOD_DEPTH) ? regs.lod_point_count : LOD_DEPTH;
    goal = 0;
    if (n == 0) begin
      goal = 64'h7FFF_FFFF;
      return 1'b1;
    end
    last = n - 1;
    if (d < lod_dist[0]) begin
      goal = lod_vert[0];
      return 1'b1;
    end
    if (lod_dist[last] < d) begin
      goal = lod_vert[last];
      return 1'b1;
    end
    for (int unsigned i = 1; i < n; i++) begin
      if (d < lod_dist[i]) begin
        num  = (longint'(lod_vert[i]) - longint'(lod_vert[i-1])) *
               longint'(32'(d - lod_dist[i-1]));
        den  = longint'(32'(lod_dist[i] - lod_dist[i-1]));
        goal = longint'(lod_vert[i-1]) + num / den;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Turns a detail change whose walk would reach an unloaded record into a restart.
  function automatic void keep_to_loaded(ref cmd_t c);
    longint goal;
    if (c.kind == REQ_SET_VERTS) begin
      if (!walk_to_target(longint'(c.target_vertices), 1'b1)) c.kind = REQ_RESTART;
    end else if (c.kind == REQ_SET_DIST) begin
      if (target_from_distance(c.distance, goal) && !walk_to_target(goal, 1'b1))
        c.kind = REQ_RESTART;
    end
  endfunction

  function automatic lod_result_t predict_request(cmd_t c);
    lod_result_t res;
    longint      goal;
    res = '0;
    case (c.kind)
      REQ_LOAD_INDEX: begin
        if (c.address < IDX_DEPTH) begin
          idx_mem[c.address] = c.word_value;
          idx_written.push_back(c.address);
        end
      end
      REQ_LOAD_CHANGE: begin
        chg_mem[c.address] = c.word_value;
      end
      REQ_LOAD_RECORD: begin
        if (c.address < REC_DEPTH) begin
          rec_mem[c.address] = '{target: c.word_value, vlose: c.vertices_to_lose,
                                 ilose: c.indices_to_lose, cstart: c.change_start,
                                 ccount: c.change_count, should: c.should_collapse};
          rec_loaded[c.address] = 1'b1;
        end
      end
      REQ_LOAD_LOD: begin
        if (c.address < LOD_DEPTH) begin
          lod_dist[c.address] = c.distance;
          lod_vert[c.address] = c.word_value;
        end
      end
      REQ_RESTART: begin
        level_ptr   = 0;
        cur_verts   = regs.min_vertices;
        cur_indices = regs.min_indices;
      end
      REQ_SET_VERTS: void'(walk_to_target(longint'(c.target_vertices), 1'b0));
      REQ_SET_DIST: begin
        if (target_from_distance(c.distance, goal)) void'(walk_to_target(goal, 1'b0));
      end
      REQ_READ_INDEX: begin
        if (c.address < IDX_DEPTH) res.word = idx_mem[c.address];
      end
      default: ;
    endcase
    res.verts   = cur_verts[15:0];
    res.indices = cur_indices[15:0];
    res.level   = level_ptr[10:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------------

  // Sends one request, keeping tvalid high across back-to-back requests. The expectation
  // is queued once the engine has taken the request.
  task automatic send_request(cmd_t c, bit typed = 1'b0, lod_result_t fixed = '0);
    lod_result_t res;
    keep_to_loaded(c);
    res = predict_request(c);
    if (typed) res = fixed;
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.kind;
    in_tdata  <= {7'd0, c.target_vertices, c.distance, c.should_collapse, c.change_count,
                  c.change_start, c.indices_to_lose, c.vertices_to_lose, c.word_value,
                  c.address};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(res);
  endtask

  // Keeps cfg_valid high across consecutive writes; the caller drops it after the last.
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COLLAPSE_COUNT:  regs.collapse_count  = value[10:0];
      CFG_LOD_POINT_COUNT: regs.lod_point_count = value[3:0];
      CFG_MIN_VERTICES:    regs.min_vertices    = value;
      CFG_MIN_INDICES:     regs.min_indices     = value;
      default: ;
    endcase
  endtask

  // Waits until every result is back, then lets the engine settle before a register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_registers(int cc, int pts, int minv, int mini);
    write_register(CFG_COLLAPSE_COUNT, 16'(cc));
    write_register(CFG_LOD_POINT_COUNT, 16'(pts));
    write_register(CFG_MIN_VERTICES, 16'(minv));
    write_register(CFG_MIN_INDICES, 16'(mini));
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t plain(req_t k, int a, int w, int tv, logic [31:0] d);
    cmd_t c;
    c = '0;
    c.kind            = k;
    c.address         = 13'(a);
    c.word_value      = 16'(w);
    c.target_vertices = 16'(tv);
    c.distance        = d;
    return c;
  endfunction

  // Record fields whose change entries stay inside what has been loaded: a span of the
  // loaded window, a long run from the last entry (all others fall past the end), or
  // an empty list starting anywhere.
  function automatic void fill_record(ref cmd_t c);
    int pick;
    int st;
    pick = $urandom_range(15);
    c.word_value       = 16'($urandom);
    c.vertices_to_lose = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    c.indices_to_lose  = 16'($urandom);
    c.should_collapse  = ($urandom_range(3) == 0);
    if (pick == 0) begin
      c.change_start = 13'h1FFF;
      c.change_count = 14'($urandom_range(1, 16383));
    end else if (pick < 3) begin
      c.change_start = 13'($urandom);
      c.change_count = '0;
    end else begin
      st = $urandom_range(CHG_WINDOW - 1);
      c.change_start = 13'(st);
      c.change_count = 14'($urandom_range(0, (CHG_WINDOW - st) < 12 ? CHG_WINDOW - st : 12));
    end
  endfunction

  function automatic cmd_t random_request();
    cmd_t c;
    int   pick;
    c = '0;
    c.target_vertices = 16'($urandom);
    c.distance        = $urandom;
    c.word_value      = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      c.kind = REQ_SET_VERTS;
      case ($urandom_range(5))
        0, 1: c.target_vertices = 16'($urandom);
        2, 3: c.target_vertices = 16'(cur_verts + $urandom_range(60) - 30);
        4:    c.target_vertices = cur_verts[15:0];
        default: c.target_vertices = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
    end else if (pick < 45) begin
      c.kind = REQ_SET_DIST;
      if ($urandom_range(1)) c.distance = $urandom_range(32'h0090_0000);
      else if ($urandom_range(3) == 0) c.distance = lod_dist[$urandom_range(LOD_DEPTH - 1)];
    end else if (pick < 53) begin
      c.kind = REQ_RESTART;
    end else if (pick < 68) begin
      c.kind = REQ_READ_INDEX;
      if ($urandom_range(4) == 0) c.address = 13'($urandom_range(8191, IDX_DEPTH));
      else c.address = 13'(idx_written[$urandom_range(idx_written.size() - 1)]);
    end else if (pick < 78) begin
      c.kind    = REQ_LOAD_INDEX;
      c.address = 13'($urandom);
    end else if (pick < 85) begin
      c.kind    = REQ_LOAD_CHANGE;
      c.address = $urandom_range(1) ? 13'($urandom) : 13'($urandom_range(CHG_WINDOW - 1));
      c.word_value = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(300));
    end else if (pick < 95) begin
      c.kind    = REQ_LOAD_RECORD;
      c.address = ($urandom_range(4) == 0) ? 13'($urandom) :
                  13'($urandom_range(SEED_RECORDS - 1));
      fill_record(c);
    end else begin
      c.kind    = REQ_LOAD_LOD;
      c.address = 13'($urandom_range(15));
      // Mostly keep the point table sorted; sometimes scramble one point.
      if (c.address < LOD_DEPTH && $urandom_range(2) != 0)
        c.distance = 32'((c.address + 1) * 32'h0010_0000 + $urandom_range(16'hFFFF));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------------
  // Checking of results
  // ---------------------------------------------------------------------------------

  always @(posedge clk) begin
    lod_result_t got;
    lod_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[58:0];
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: %h", got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.word !== want.word) begin
            $error("read_word: expected %0d, got %0d", want.word, got.word);
            errors++;
          end
          if (got.verts !== want.verts) begin
            $error("vertex_count: expected %0d, got %0d", want.verts, got.verts);
            errors++;
          end
          if (got.indices !== want.indices) begin
            $error("index_count: expected %0d, got %0d", want.indices, got.indices);
            errors++;
          end
          if (got.level !== want.level) begin
            $error("detail_level: expected %0d, got %0d", want.level, got.level);
            errors++;
          end
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  // In the last phase the receiver stops for a long stretch at the start, so that the
  // request queue and the result register fill and the engine holds off its input.
  initial begin
    rx_hold = 1'b0;
    wait (phase == 3);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------

  lod_row_t lod_rows [$];

  initial begin
    cmd_t c;
    int   seed_point;

    errors = 0;
    phase  = 0;
    tx_idle = 12;
    rx_idle = 79;
    regs = '0;
    level_ptr = 0;
    cur_verts = 0;
    cur_indices = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // Rows up to the seeding point run on the reset state, where every answer is zero.
    lod_rows.push_back('{plain(REQ_RESTART, 0, 0, 0, 0), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_READ_INDEX, 4096, 0, 0, 0), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_READ_INDEX, 8191, 0, 0, 0), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_LOAD_INDEX, 8191, 16'hFFFF, 0, 0), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_SET_VERTS, 0, 0, 0, 0), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 32'hFFFF_FFFF), 1'b1, '0});
    lod_rows.push_back('{plain(REQ_LOAD_LOD, 8, 16'hFFFF, 0, 32'hFFFF_FFFF), 1'b1, '0});
    c = '1;
    c.kind = REQ_LOAD_RECORD;
    lod_rows.push_back('{c, 1'b1, '0});
    seed_point = lod_rows.size();
    // From here on the predictor supplies the answers.
    lod_rows.push_back('{plain(REQ_RESTART, 0, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_VERTS, 0, 0, 16'hFFFF, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_VERTS, 0, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 32'h0080_0000), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 32'h0028_0000), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_READ_INDEX, 0, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_READ_INDEX, 63, 0, 0, 0), 1'b0, '0});
    c = '1;
    c.kind    = REQ_LOAD_RECORD;
    c.address = 13'd1023;
    lod_rows.push_back('{c, 1'b0, '0});
    lod_rows.push_back('{plain(REQ_LOAD_CHANGE, 8191, 16'hFFFF, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_LOAD_INDEX, 4095, 16'hFFFF, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_READ_INDEX, 4095, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_RESTART, 0, 0, 0, 0), 1'b0, '0});
    lod_rows.push_back('{plain(REQ_SET_DIST, 0, 0, 0, 32'h0010_0000), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    phase <= 1;
    @(posedge clk);

    for (int i = 0; i < lod_rows.size(); i++) begin
      if (i == seed_point) begin
        // Load a change window, a run of records, the point table and some index words,
        // then bring the registers to the first working setting.
        for (int a = 0; a < CHG_WINDOW; a++)
          send_request(plain(REQ_LOAD_CHANGE, a, $urandom_range(300), 0, 0));
        send_request(plain(REQ_LOAD_CHANGE, 8191, $urandom_range(300), 0, 0));
        for (int a = 0; a < SEED_RECORDS; a++) begin
          c = plain(REQ_LOAD_RECORD, a, 0, 0, 0);
          fill_record(c);
          send_request(c);
        end
        for (int a = 0; a < LOD_DEPTH; a++)
          send_request(plain(REQ_LOAD_LOD, a, 20 + a * 70, 0, (a + 1) * 32'h0010_0000));
        for (int a = 0; a < 64; a++)
          send_request(plain(REQ_LOAD_INDEX, a, $urandom, 0, 0));
        drain();
        set_registers(SEED_RECORDS, 8, 10, 30);
      end
      send_request(lod_rows[i].cmd, lod_rows[i].typed, lod_rows[i].fixed);
    end

    for (int i = 0; i < RAND_PER_PHASE; i++) send_request(random_request());

    // Second setting: every record slot counted, point count above the table size.
    drain();
    tx_idle = 79;
    rx_idle = 12;
    phase   = 2;
    set_registers(REC_DEPTH, 15, 0, 0);
    for (int i = 0; i < RAND_PER_PHASE / 3; i++) send_request(random_request());
    drain();
    set_registers(SEED_RECORDS / 2, 3, 5, 65535);
    for (int i = 0; i < RAND_PER_PHASE - RAND_PER_PHASE / 3; i++)
      send_request(random_request());

    // Third setting: counts start at the top of their range and wrap; nobody idles.
    drain();
    tx_idle = 0;
    rx_idle = 0;
    set_registers(20, 1, 65535, 65535);
    phase = 3;
    for (int i = 0; i < RAND_PER_PHASE; i++) send_request(random_request());

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
